FILE: design/ptm_pkg.sv
// package for the pseudo transverse mass block
// shared constants and cordic angle table; no dependencies
`default_nettype none
package ptm_pkg;
    localparam int MOMENTUM_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STEPS      = 30;
    localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;
    // cordic datapath width: q16 momenta with gain and headroom
    localparam int DW = 56;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        case (i)
            5'd0:  atan_lut = 32'h20000000; 5'd1:  atan_lut = 32'h12E4051E;
            5'd2:  atan_lut = 32'h09FB385B; 5'd3:  atan_lut = 32'h051111D4;
            5'd4:  atan_lut = 32'h028B0D43; 5'd5:  atan_lut = 32'h0145D7E1;
            5'd6:  atan_lut = 32'h00A2F61E; 5'd7:  atan_lut = 32'h00517C55;
            5'd8:  atan_lut = 32'h0028BE53; 5'd9:  atan_lut = 32'h00145F2F;
            5'd10: atan_lut = 32'h000A2F98; 5'd11: atan_lut = 32'h000517CC;
            5'd12: atan_lut = 32'h00028BE6; 5'd13: atan_lut = 32'h000145F3;
            5'd14: atan_lut = 32'h0000A2FA; 5'd15: atan_lut = 32'h0000517D;
            5'd16: atan_lut = 32'h000028BE; 5'd17: atan_lut = 32'h0000145F;
            5'd18: atan_lut = 32'h00000A30; 5'd19: atan_lut = 32'h00000518;
            5'd20: atan_lut = 32'h0000028C; 5'd21: atan_lut = 32'h00000146;
            5'd22: atan_lut = 32'h000000A3; 5'd23: atan_lut = 32'h00000051;
            5'd24: atan_lut = 32'h00000029; 5'd25: atan_lut = 32'h00000014;
            5'd26: atan_lut = 32'h0000000A; 5'd27: atan_lut = 32'h00000005;
            5'd28: atan_lut = 32'h00000003; 5'd29: atan_lut = 32'h00000001;
            default: atan_lut = 32'h0;
        endcase
    endfunction
endpackage
`default_nettype wire

FILE: design/ptm_front.sv
// front part: takes requests, widens angles and scales momenta by the cordic gain
// depends on ptm_pkg
`default_nettype none
module ptm_front #(
    parameter int MOMENTUM_BITS = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [MOMENTUM_BITS-1:0] i_pm,
    input  wire logic [ANGLE_BITS-1:0]    i_am,
    input  wire logic [MOMENTUM_BITS-1:0] i_pn,
    input  wire logic [ANGLE_BITS-1:0]    i_an,
    input  wire logic [MOMENTUM_BITS-1:0] i_pp,
    input  wire logic [ANGLE_BITS-1:0]    i_ap,
    input  wire logic                     i_q_ready,
    output logic                          o_q_valid,
    output logic [ptm_pkg::DW-1:0]        o_xm,
    output logic [31:0]                   o_am,
    output logic [ptm_pkg::DW-1:0]        o_xn,
    output logic [31:0]                   o_an,
    output logic [MOMENTUM_BITS-1:0]      o_pp,
    output logic [31:0]                   o_ap
);
    import ptm_pkg::*;
    localparam int PW = MOMENTUM_BITS + 32;
    logic          r_v;
    logic [PW-1:0] w_pm, w_pn;

    assign o_ready = !r_v || i_q_ready;
    assign w_pm = PW'(i_pm) * PW'(GAIN_Q30);
    assign w_pn = PW'(i_pn) * PW'(GAIN_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            o_xm <= DW'(w_pm >> 14);
            o_xn <= DW'(w_pn >> 14);
            o_am <= {i_am, {(32-ANGLE_BITS){1'b0}}};
            o_an <= {i_an, {(32-ANGLE_BITS){1'b0}}};
            o_ap <= {i_ap, {(32-ANGLE_BITS){1'b0}}};
            o_pp <= i_pp;
        end
    end
    assign o_q_valid = r_v;
endmodule
`default_nettype wire

FILE: design/ptm_back.sv
// back part: pipelined cordics, magnitude, sqrt and final scaling
// depends on ptm_pkg
`default_nettype none
module ptm_back #(
    parameter int MOMENTUM_BITS = ptm_pkg::MOMENTUM_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [ptm_pkg::DW-1:0]   i_xm,
    input  wire logic [31:0]              i_am,
    input  wire logic [ptm_pkg::DW-1:0]   i_xn,
    input  wire logic [31:0]              i_an,
    input  wire logic [MOMENTUM_BITS-1:0] i_pp,
    input  wire logic [31:0]              i_ap,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [MOMENTUM_BITS-1:0]      o_mt,
    output logic                          o_sat
);
    import ptm_pkg::*;
    localparam int N   = CORDIC_STEPS;
    localparam int RW  = MOMENTUM_BITS + 18;    // magnitude R q16 width
    localparam int MW  = MOMENTUM_BITS + RW;    // pt_pos * R product
    localparam int GW  = MW / 2;                // sqrt root width
    localparam int VL  = 18;                    // low slice of the vectoring magnitude
    localparam int VH  = RW + 1 - VL;           // high slice of the vectoring magnitude
    localparam int PW  = RW + 33;               // magnitude times gain
    // stages: 1 prep, N rotation, 1 add, 1 prep, N vectoring, 1 mag product, 1 diff,
    // N sin rotation, 1 clamp, 1 product, GW sqrt, 1 mul, 1 out
    // (the magnitude sum stage runs beside the diff stage)
    localparam int NST = 3*N + GW + 8;

    logic             w_adv;
    logic [NST-1:0]   r_v;
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // rotation pipeline for both vectors
    logic signed [DW-1:0] r_mx [N+1], r_my [N+1], r_nx [N+1], r_ny [N+1];
    logic signed [33:0]   r_mz [N+1], r_nz [N+1];
    logic [MOMENTUM_BITS-1:0] r_pp [3*N+6];
    logic [31:0]          r_ap [2*N+4];
    // vectoring
    logic signed [DW-1:0] r_vx [N+1], r_vy [N+1];
    logic signed [33:0]   r_vz [N+1];
    logic [31:0]          r_vb [N+1];
    logic signed [DW-1:0] r_sx, r_sy;
    logic [VL+31:0]       r_mlo;
    logic [VH+31:0]       r_mhi;
    logic [RW-1:0]        r_mag [N+2];
    logic [31:0]          r_phr;
    // sin rotation
    logic signed [DW-1:0] r_cx [N+1], r_cy [N+1];
    logic signed [33:0]   r_cz [N+1];
    logic [30:0]          r_sn [GW+2];
    // sqrt, two radicand bits per stage
    logic [GW+1:0]        r_rem [GW];
    logic [GW-1:0]        r_root [GW+1];
    logic [MW-1:0]        r_rad [GW];
    logic [GW+31:0]       r_prod;

    function automatic logic signed [33:0] rot_z(input logic [31:0] a);
        rot_z = {{2{a[31]}}, a};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (w_adv) begin
            r_v     <= {r_v[NST-2:0], i_valid};
            o_valid <= r_v[NST-1];
        end
    end

    logic [31:0] w_am, w_an;
    logic        w_fm, w_fn;
    logic [31:0] w_diff;
    logic [31:0] w_half, w_hz;
    logic        w_fc;
    logic [VL+31:0] w_mlo;
    logic [VH+31:0] w_mhi;
    logic [GW+1:0]  w_rem2 [GW];
    logic [GW+1:0]  w_try [GW];
    logic [GW-1:0]  w_ge;
    assign w_fm = (i_am[31:30] == 2'd1) || (i_am[31:30] == 2'd2);
    assign w_fn = (i_an[31:30] == 2'd1) || (i_an[31:30] == 2'd2);
    assign w_am = w_fm ? i_am - 32'h80000000 : i_am;
    assign w_an = w_fn ? i_an - 32'h80000000 : i_an;
    // magnitude times gain in two slices
    assign w_mlo = (VL+32)'(r_vx[N][VL-1:0]) * (VL+32)'(GAIN_Q30);
    assign w_mhi = (VH+32)'(r_vx[N][RW:VL]) * (VH+32)'(GAIN_Q30);
    assign w_diff = (r_ap[2*N+3] - r_phr > 32'h80000000) ? r_phr - r_ap[2*N+3]
                                                       : r_ap[2*N+3] - r_phr;
    // half angle, folded like any other rotation input (d = pi lands on the fold)
    assign w_half = {1'b0, w_diff[31:1]};
    assign w_fc   = (w_half[31:30] == 2'd1) || (w_half[31:30] == 2'd2);
    assign w_hz   = w_fc ? w_half - 32'h80000000 : w_half;

    always_comb begin
        for (int b = 0; b < GW; b++) begin
            w_rem2[b] = {r_rem[b][GW-1:0], r_rad[b][MW-1:MW-2]};
            w_try[b]  = {r_root[b], 2'b01};
            w_ge[b]   = (w_rem2[b] >= w_try[b]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // stage 0: quadrant fold
            r_mx[0] <= w_fm ? -$signed(i_xm) : $signed(i_xm);
            r_nx[0] <= w_fn ? -$signed(i_xn) : $signed(i_xn);
            r_my[0] <= '0;
            r_ny[0] <= '0;
            r_mz[0] <= rot_z(w_am);
            r_nz[0] <= rot_z(w_an);
            r_pp[0] <= i_pp;
            r_ap[0] <= i_ap;
            for (int i = 0; i < N; i++) begin
                if (!r_mz[i][33]) begin
                    r_mx[i+1] <= r_mx[i] - (r_my[i] >>> i);
                    r_my[i+1] <= r_my[i] + (r_mx[i] >>> i);
                    r_mz[i+1] <= r_mz[i] - 34'(atan_lut(5'(i)));
                end else begin
                    r_mx[i+1] <= r_mx[i] + (r_my[i] >>> i);
                    r_my[i+1] <= r_my[i] - (r_mx[i] >>> i);
                    r_mz[i+1] <= r_mz[i] + 34'(atan_lut(5'(i)));
                end
                if (!r_nz[i][33]) begin
                    r_nx[i+1] <= r_nx[i] - (r_ny[i] >>> i);
                    r_ny[i+1] <= r_ny[i] + (r_nx[i] >>> i);
                    r_nz[i+1] <= r_nz[i] - 34'(atan_lut(5'(i)));
                end else begin
                    r_nx[i+1] <= r_nx[i] + (r_ny[i] >>> i);
                    r_ny[i+1] <= r_ny[i] - (r_nx[i] >>> i);
                    r_nz[i+1] <= r_nz[i] + 34'(atan_lut(5'(i)));
                end
            end
            for (int i = 0; i < 2*N+3; i++) r_ap[i+1] <= r_ap[i];
            for (int i = 0; i < 3*N+5; i++) r_pp[i+1] <= r_pp[i];
            // sum, then vectoring fold
            r_sx <= r_mx[N] + r_nx[N];
            r_sy <= r_my[N] + r_ny[N];
            r_vx[0] <= r_sx[DW-1] ? -r_sx : r_sx;
            r_vy[0] <= r_sx[DW-1] ? -r_sy : r_sy;
            r_vb[0] <= r_sx[DW-1] ? 32'h80000000 : 32'h0;
            r_vz[0] <= '0;
            for (int i = 0; i < N; i++) begin
                r_vb[i+1] <= r_vb[i];
                if (r_vy[i][DW-1]) begin
                    r_vx[i+1] <= r_vx[i] - (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] + (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] - 34'(atan_lut(5'(i)));
                end else begin
                    r_vx[i+1] <= r_vx[i] + (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] - (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] + 34'(atan_lut(5'(i)));
                end
            end
            // magnitude and azimuth
            r_mlo    <= w_mlo;
            r_mhi    <= w_mhi;
            r_mag[0] <= RW'(((PW'(r_mhi) << VL) + PW'(r_mlo)) >> 30);
            r_phr    <= r_vb[N] + r_vz[N][31:0];
            for (int i = 0; i < N+1; i++) r_mag[i+1] <= r_mag[i];
            // sin(d/2) rotation
            r_cx[0] <= w_fc ? -DW'(GAIN_Q30) : DW'(GAIN_Q30);
            r_cy[0] <= '0;
            r_cz[0] <= rot_z(w_hz);
            for (int i = 0; i < N; i++) begin
                if (!r_cz[i][33]) begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - 34'(atan_lut(5'(i)));
                end else begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + 34'(atan_lut(5'(i)));
                end
            end
            r_sn[0] <= r_cy[N][DW-1] ? 31'd0 :
                       (r_cy[N] > DW'(32'h40000000)) ? 31'h40000000 : 31'(r_cy[N]);
            for (int i = 0; i < GW+1; i++) r_sn[i+1] <= r_sn[i];
            // radicand pt_pos * R, then one root bit per stage
            r_rad[0]  <= MW'(r_pp[3*N+5]) * MW'(r_mag[N+1]);
            r_root[0] <= '0;
            r_rem[0]  <= '0;
            for (int b = 0; b < GW; b++) begin
                r_root[b+1] <= {r_root[b][GW-2:0], w_ge[b]};
            end
            for (int b = 0; b < GW-1; b++) begin
                r_rem[b+1] <= w_ge[b] ? w_rem2[b] - w_try[b] : w_rem2[b];
                r_rad[b+1] <= r_rad[b] << 2;
            end
            r_prod <= (GW+32)'(r_root[GW]) * (GW+32)'(r_sn[GW+1]);
            if ((r_prod >> 37) > (GW+32)'({MOMENTUM_BITS{1'b1}})) begin
                o_mt  <= '1;
                o_sat <= 1'b1;
            end else begin
                o_mt  <= MOMENTUM_BITS'(r_prod >> 37);
                o_sat <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/pseudo_transverse_mass.sv
// top level of the pseudo transverse mass block
// depends on ptm_pkg, ptm_front and ptm_back
`default_nettype none
// Pseudo transverse mass: one event per request on s_axis, one result on
// m_axis. Missing momentum and the negative lepton are rotated to x/y by
// pipelined cordics, summed, vectored back to magnitude and azimuth, and the
// folded azimuth difference to the positive lepton gives sqrt(2*pt*R*(1-cos)).
// The back pipeline holds as a whole while a result waits on m_axis_tready;
// the front register then keeps one more request. Otherwise throughput is
// one event per clock. From the accepting edge to m_axis_tvalid lie the front
// register, 3*30 cordic stages, MOMENTUM_BITS+9 root stages (two radicand bits
// each) and the prep, add, product, diff, clamp, mul and out registers.
module pseudo_transverse_mass #(
    parameter int MOMENTUM_BITS = ptm_pkg::MOMENTUM_BITS_DEF,
    parameter int ANGLE_BITS    = ptm_pkg::ANGLE_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // met_pt, met_angle, neg_lepton_pt, neg_lepton_angle, pos_lepton_pt,
    // pos_lepton_angle from the lowest bit up
    input  wire logic [((3*MOMENTUM_BITS+3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // pseudo_mt, saturated from the lowest bit up
    output logic [((MOMENTUM_BITS+8)/8)*8-1:0] m_axis_tdata
);
    import ptm_pkg::*;
    localparam int M = MOMENTUM_BITS;
    localparam int A = ANGLE_BITS;
    localparam int OW = ((MOMENTUM_BITS+8)/8)*8;
    logic q_valid, q_ready;
    logic [DW-1:0] xm, xn;
    logic [31:0]   am, an, ap;
    logic [M-1:0]  pp, mt;
    logic          sat;

    ptm_front #(.MOMENTUM_BITS(M), .ANGLE_BITS(A)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_pm(s_axis_tdata[M-1:0]),       .i_am(s_axis_tdata[M+A-1:M]),
        .i_pn(s_axis_tdata[2*M+A-1:M+A]), .i_an(s_axis_tdata[2*M+2*A-1:2*M+A]),
        .i_pp(s_axis_tdata[3*M+2*A-1:2*M+2*A]),
        .i_ap(s_axis_tdata[3*M+3*A-1:3*M+2*A]),
        .i_q_ready(q_ready), .o_q_valid(q_valid),
        .o_xm(xm), .o_am(am), .o_xn(xn), .o_an(an), .o_pp(pp), .o_ap(ap)
    );

    ptm_back #(.MOMENTUM_BITS(M)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready),
        .i_xm(xm), .i_am(am), .i_xn(xn), .i_an(an), .i_pp(pp), .i_ap(ap),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_mt(mt), .o_sat(sat)
    );

    assign m_axis_tdata = OW'({sat, mt});
endmodule
`default_nettype wire
